// ----- hdl/dds_pkg.sv -----
// dds_pkg: shared types and fixed constants of the table-driven oscillator
package dds_pkg;

  // waveform selector codes, values above WAVE_SILENT also give silence
  typedef enum logic [2:0] {
    WAVE_SINE   = 3'd0,
    WAVE_SQUARE = 3'd1,
    WAVE_RAMP   = 3'd2,
    WAVE_MIXED  = 3'd3,
    WAVE_SILENT = 3'd4
  } wave_mode_t;

  // configuration register indexes
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_SELECT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP      = 4'd1;

  localparam int CFG_DATA_W = 32;
  localparam int PHASE_W    = 32;
  localparam int SAMPLE_W   = 16;

  // reset value of the phase step register
  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd167391;

  // both phase accumulators, Q16.16
  typedef struct packed {
    logic [PHASE_W-1:0] fast;
    logic [PHASE_W-1:0] slow;
  } phase_pair_t;

  // Q2.30 constants for the elaboration-time sine build
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned TEN_Q30     = 64'd10 << 30;
  localparam int              TAYLOR_TERMS = 12;

  // Taylor series divisors: (2n-1)(2n) for cosine, (2n)(2n+1) for sine
  localparam longint unsigned COS_DIV [TAYLOR_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};
  localparam longint unsigned SIN_DIV [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

endpackage

// ----- hdl/dds_phase_acc.sv -----
// dds_phase_acc: fast and slow Q16.16 phase accumulators
module dds_phase_acc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [dds_pkg::PHASE_W-1:0]   phase_step,
  output dds_pkg::phase_pair_t          phases
);
  import dds_pkg::*;

  // slow accumulator runs at half the step, both wrap modulo 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      phases <= '0;
    end else if (advance) begin
      phases.fast <= phases.fast + phase_step;
      phases.slow <= phases.slow + {1'b0, phase_step[PHASE_W-1:1]};
    end
  end

endmodule

// ----- hdl/dds_wave_gen.sv -----
// dds_wave_gen: constant waveform tables and per-sample waveform selection
module dds_wave_gen #(
  parameter int TABLE_DEPTH = 256,
  parameter int PEAK_LEVEL  = 16000
) (
  input  dds_pkg::phase_pair_t                phases,
  input  dds_pkg::wave_mode_t                 mode,
  output logic signed [dds_pkg::SAMPLE_W-1:0] sample
);
  import dds_pkg::*;

  // table depth is a power of two, so the index is a bit slice of the phase
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic signed [SAMPLE_W-1:0] PEAK_POS = SAMPLE_W'(PEAK_LEVEL);
  localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = SAMPLE_W'(-PEAK_LEVEL);

  // sin(2*pi*k/depth) in Q2.30 by quadrant reduction and Taylor series
  function automatic longint sin_q30(input longint unsigned k);
    longint unsigned q;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint          acc;
    q    = 64'd4 * k;
    quad = q / TABLE_DEPTH;
    r    = q % TABLE_DEPTH;
    t    = (HALF_PI_Q30 * r) / TABLE_DEPTH;
    t2   = (t * t) >> 30;
    if (quad[0]) begin
      term = ONE_Q30;
      acc  = longint'(ONE_Q30);
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        term = ((term * t2) >> 30) / COS_DIV[n];
        if (n[0] == 1'b0) acc = acc - longint'(term);
        else              acc = acc + longint'(term);
      end
    end else begin
      term = t;
      acc  = longint'(t);
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        term = ((term * t2) >> 30) / SIN_DIV[n];
        if (n[0] == 1'b0) acc = acc - longint'(term);
        else              acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    return (quad >= 64'd2) ? -acc : acc;
  endfunction

  // full amplitude: trunc(peak * s / 2^30)
  function automatic logic signed [SAMPLE_W-1:0] scale_unit(input longint s);
    longint unsigned mag;
    longint unsigned v;
    logic signed [SAMPLE_W-1:0] r16;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    v   = (64'(PEAK_LEVEL) * mag) >> 30;
    r16 = SAMPLE_W'(v);
    return (s < 0) ? -r16 : r16;
  endfunction

  // fractional amplitude in tenths: trunc(peak * num / 10 * s / 2^30)
  function automatic logic signed [SAMPLE_W-1:0] scale_tenths(input longint s,
                                                              input longint unsigned num);
    longint unsigned mag;
    longint unsigned v;
    logic signed [SAMPLE_W-1:0] r16;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    v   = (64'(PEAK_LEVEL) * num * mag) / TEN_Q30;
    r16 = SAMPLE_W'(v);
    return (s < 0) ? -r16 : r16;
  endfunction

  // ramp: trunc(peak * (2k - depth) / depth)
  function automatic logic signed [SAMPLE_W-1:0] ramp_entry(input longint k);
    longint num;
    num = longint'(PEAK_LEVEL) * (64'sd2 * k - longint'(TABLE_DEPTH));
    return SAMPLE_W'(num / TABLE_DEPTH);
  endfunction

  logic signed [SAMPLE_W-1:0] sine_tab      [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] tone_low_tab  [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] tone_high_tab [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] ramp_tab      [TABLE_DEPTH];

  // constant tables, one entry per index, built at elaboration
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_tab
    localparam longint S1 = sin_q30(64'(k));
    localparam longint S4 = sin_q30(64'((4 * k) % TABLE_DEPTH));
    localparam logic signed [SAMPLE_W-1:0] SINE_V = scale_unit(S1);
    localparam logic signed [SAMPLE_W-1:0] LOW_V  = scale_tenths(S1, 64'd6);
    localparam logic signed [SAMPLE_W-1:0] HIGH_V = scale_tenths(S4, 64'd4);
    localparam logic signed [SAMPLE_W-1:0] RAMP_V = ramp_entry(64'(k));
    assign sine_tab[k]      = SINE_V;
    assign tone_low_tab[k]  = LOW_V;
    assign tone_high_tab[k] = HIGH_V;
    assign ramp_tab[k]      = RAMP_V;
  end

  logic [IDX_W-1:0]           fast_idx;
  logic [IDX_W-1:0]           slow_idx;
  logic signed [SAMPLE_W:0]   mix_sum;
  logic signed [SAMPLE_W+2:0] mix_x3;
  logic signed [SAMPLE_W+2:0] mix_adj;
  logic signed [SAMPLE_W+2:0] mix_q;

  // table indexes from the integer part of each phase
  assign fast_idx = phases.fast[16 +: IDX_W];
  assign slow_idx = phases.slow[16 +: IDX_W];

  // two-tone mix: 3 * (low + high) / 4, truncated toward zero
  always_comb begin
    mix_sum = {tone_low_tab[slow_idx][SAMPLE_W-1], tone_low_tab[slow_idx]}
            + {tone_high_tab[fast_idx][SAMPLE_W-1], tone_high_tab[fast_idx]};
    mix_x3  = (SAMPLE_W+3)'(mix_sum) + ((SAMPLE_W+3)'(mix_sum) <<< 1);
    mix_adj = mix_x3 + (mix_x3[SAMPLE_W+2] ? (SAMPLE_W+3)'(3) : (SAMPLE_W+3)'(0));
    mix_q   = mix_adj >>> 2;
  end

  // waveform select
  always_comb begin
    case (mode)
      WAVE_SINE:   sample = sine_tab[fast_idx];
      WAVE_SQUARE: sample = fast_idx[IDX_W-1] ? PEAK_NEG : PEAK_POS;
      WAVE_RAMP:   sample = ramp_tab[fast_idx];
      WAVE_MIXED:  sample = mix_q[SAMPLE_W-1:0];
      default:     sample = '0;
    endcase
  end

endmodule

// ----- hdl/dds_waveform_generator.sv -----
// dds_waveform_generator: table-driven oscillator, top level with handshake and config
// Latency: a sample word is registered and appears in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle unless a pending sample word is held by out_ready low;
//   the path phase register -> table read -> two-tone adder -> sample register sets the clock.
// A tick word with tick low gives no sample and leaves the phases unchanged.
// Reset: phases zero, sine mode, default phase step, no sample word pending.
module dds_waveform_generator #(
  parameter int TABLE_DEPTH = 256,
  parameter int PEAK_LEVEL  = 16000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                tick,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dds_pkg::SAMPLE_W-1:0] left_sample,
  output logic signed [dds_pkg::SAMPLE_W-1:0] right_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dds_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dds_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dds_pkg::*;

  wave_mode_t                 waveform_select;
  logic [PHASE_W-1:0]         phase_step;
  phase_pair_t                phases;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       in_accept;
  logic                       advance;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_select <= WAVE_SINE;
      phase_step      <= PHASE_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAVEFORM_SELECT: waveform_select <= wave_mode_t'(cfg_data[2:0]);
        REG_PHASE_STEP:      phase_step      <= cfg_data[PHASE_W-1:0];
        default:             ;
      endcase
    end
  end

  // take a new word whenever the sample register is free or being emptied
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign advance   = in_accept && tick;

  dds_phase_acc u_phase_acc (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .phase_step (phase_step),
    .phases     (phases)
  );

  dds_wave_gen #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PEAK_LEVEL  (PEAK_LEVEL)
  ) u_wave_gen (
    .phases (phases),
    .mode   (waveform_select),
    .sample (sample)
  );

  // sample word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= tick;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sample register, same value to both channels
  always_ff @(posedge clk) begin
    if (advance) begin
      left_sample  <= sample;
      right_sample <= sample;
    end
  end

  // a sample request moves the fast phase by exactly one step
  assert property (@(posedge clk) disable iff (rst)
    advance |=> phases.fast == $past(phases.fast) + $past(phase_step))
    else $error("fast phase did not advance by the step");

  // the slow phase moves by half the step on a request
  assert property (@(posedge clk) disable iff (rst)
    advance |=> phases.slow == $past(phases.slow) + {1'b0, $past(phase_step[PHASE_W-1:1])})
    else $error("slow phase did not advance by half the step");

  // without a sample request the phases hold
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phases))
    else $error("phases moved without a sample request");

  // silent and unused codes give a zero sample word
  assert property (@(posedge clk) disable iff (rst)
    (advance && waveform_select != WAVE_SINE && waveform_select != WAVE_SQUARE &&
     waveform_select != WAVE_RAMP && waveform_select != WAVE_MIXED)
    |=> out_valid && left_sample == '0)
    else $error("silent mode produced a nonzero sample");

endmodule
